// ===== hw/rtl/rgb565_to_mono_frame_scaler_core_assert.svh =====
// Assertion macros shared by the frame scaler RTL.
// No dependencies; each macro takes the clock and reset of the module that uses it.
`ifndef RGB565_TO_MONO_FRAME_SCALER_CORE_ASSERT_SVH
`define RGB565_TO_MONO_FRAME_SCALER_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent
`define RMFS_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmfs: same-cycle check failed");

// Consequent checked in the cycle after the antecedent
`define RMFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmfs: next-cycle check failed");

`endif

// ===== hw/rtl/rmfs_pkg.sv =====
// Package for the RGB565 to mono frame scaler: geometry, widths, codes and types.
// No dependencies; used by every RTL file except the assertion macro header.
`default_nettype none

package rmfs_pkg;

  // Frame and panel geometry
  localparam int LOGICAL_WIDTH  = 480;
  localparam int LOGICAL_HEIGHT = 480;
  localparam int PANEL_WIDTH    = 400;
  localparam int PANEL_HEIGHT   = 300;

  // Field widths
  localparam int COORD_W = 10;
  localparam int COLOR_W = 16;
  localparam int LUMA_W  = 8;

  // Centered square on the panel
  localparam int SQUARE_SIDE  = (PANEL_WIDTH < PANEL_HEIGHT) ? PANEL_WIDTH : PANEL_HEIGHT;
  localparam int SQUARE_OFF_X = (PANEL_WIDTH - SQUARE_SIDE) / 2;
  localparam int SQUARE_OFF_Y = (PANEL_HEIGHT - SQUARE_SIDE) / 2;
  localparam int LOGICAL_MAX  = (LOGICAL_WIDTH > LOGICAL_HEIGHT) ? LOGICAL_WIDTH : LOGICAL_HEIGHT;

  // Bit store, one entry per logical pixel, row major
  localparam int STORE_BITS = LOGICAL_WIDTH * LOGICAL_HEIGHT;
  localparam int ADDR_W     = $clog2(STORE_BITS);

  // Scale divider: offset*LOGICAL fits PROD_W bits, reciprocal of the square side
  localparam int PROD_W = $clog2(SQUARE_SIDE * LOGICAL_MAX);
  localparam int RECIP  = (1 << PROD_W) / SQUARE_SIDE;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

  // BT.601 luma weights and channel layout
  localparam int LUMA_KR = 77;
  localparam int LUMA_KG = 150;
  localparam int LUMA_KB = 29;
  localparam int R_BITS  = 5;
  localparam int G_BITS  = 6;
  localparam int B_BITS  = 5;
  localparam logic [LUMA_W-1:0] LUMA_THRESHOLD_RESET = 8'd64;

  // Request kinds
  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_READ,
    CMD_REPLY
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t           op;
    logic [ADDR_W-1:0] addr;
    logic              white;
  } cmd_t;

  typedef enum logic [2:0] {
    F_IDLE,
    F_SCALE,
    F_RECIP,
    F_FIX,
    F_ADDR,
    F_PUSH
  } front_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rmfs_ifs.sv =====
// Valid/ready channel interfaces for request items and result items.
// Depends on rmfs_pkg for field widths.
`default_nettype none

interface rmfs_req_if;
  import rmfs_pkg::*;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic [COORD_W-1:0] coord_x;
  logic [COORD_W-1:0] coord_y;
  logic [COLOR_W-1:0] rgb_color;

  modport source (output valid, req_type, coord_x, coord_y, rgb_color, input ready);
  modport sink   (input valid, req_type, coord_x, coord_y, rgb_color, output ready);
endinterface

interface rmfs_rsp_if;
  logic valid;
  logic ready;
  logic pixel_white;
  logic in_range;

  modport source (output valid, pixel_white, in_range, input ready);
  modport sink   (input valid, pixel_white, in_range, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/rgb565_to_mono_frame_scaler_core.sv =====
// Top level of the RGB565 to mono frame scaler: front end, command queue, back end.
// Depends on rmfs_pkg, rmfs_ifs, rmfs_front, rmfs_queue and rmfs_back.
//
//   channel | role  | carries
//   --------+-------+---------------------------------------------------------
//   req     | sink  | req_type, coord_x, coord_y, rgb_color
//   rsp     | source| pixel_white, in_range
//   cfg     | write | cfg_wdata -> luma_threshold on cfg_we
//
// Front end takes one item at a time: an item outside the frame or square goes
// to F_PUSH, a write via F_ADDR, a read in the square via F_SCALE, F_RECIP and
// F_FIX twice (two passes of the shared scale/reciprocal-divide unit, one per
// axis) then F_ADDR. Back end retires one command per cycle unless rsp stalls,
// from a 4-entry queue into a 1-bit-wide store. After reset a clearing pass writes
// white to all STORE_BITS entries, req.ready low; cfg writes are taken throughout.
// A stalled rsp holds in the output register; the queue lets the front keep going.
`default_nettype none

module rgb565_to_mono_frame_scaler_core (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [rmfs_pkg::LUMA_W-1:0] cfg_wdata,
  rmfs_req_if.sink                    req,
  rmfs_rsp_if.source                  rsp
);
  import rmfs_pkg::*;

  logic clearing;
  logic push, full, pop, empty;
  cmd_t push_cmd, pop_cmd;

  // Classify and compute
  rmfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .clearing  (clearing),
    .req       (req),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (full)
  );

  // Decoupling queue
  rmfs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .empty    (empty)
  );

  // Store access and results
  rmfs_back u_back (
    .clk      (clk),
    .rst      (rst),
    .empty    (empty),
    .pop_cmd  (pop_cmd),
    .pop      (pop),
    .clearing (clearing),
    .rsp      (rsp)
  );

endmodule

`default_nettype wire

// ===== hw/rtl/rmfs_front.sv =====
// Front end: accepts request items, classifies them, computes luma or the scaled
// coordinate, and pushes one command per item. Depends on rmfs_pkg, rmfs_req_if.
`default_nettype none

module rmfs_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [rmfs_pkg::LUMA_W-1:0] cfg_wdata,
  input  logic                       clearing,
  rmfs_req_if.sink                   req,
  output logic                       push,
  output rmfs_pkg::cmd_t             push_cmd,
  input  logic                       full
);
  import rmfs_pkg::*;

  localparam logic [COORD_W:0] LW_C     = (COORD_W+1)'(LOGICAL_WIDTH);
  localparam logic [COORD_W:0] LH_C     = (COORD_W+1)'(LOGICAL_HEIGHT);
  localparam logic [COORD_W:0] SQ_X_LO  = (COORD_W+1)'(SQUARE_OFF_X);
  localparam logic [COORD_W:0] SQ_X_HI  = (COORD_W+1)'(SQUARE_OFF_X + SQUARE_SIDE);
  localparam logic [COORD_W:0] SQ_Y_LO  = (COORD_W+1)'(SQUARE_OFF_Y);
  localparam logic [COORD_W:0] SQ_Y_HI  = (COORD_W+1)'(SQUARE_OFF_Y + SQUARE_SIDE);
  localparam int               RPROD_W  = 2 * PROD_W + COORD_W;

  front_state_t       state, state_next;
  logic [LUMA_W-1:0]  luma_threshold;
  logic               kind;
  logic [COORD_W-1:0] cx, cy;
  logic [COLOR_W-1:0] color;
  logic               axis;
  logic [PROD_W-1:0]  prod;
  logic [COORD_W-1:0] qest;
  logic [COORD_W-1:0] sx, sy;
  cmd_t               cmd;

  logic               accept;
  logic               in_frame, in_square;
  logic [COORD_W-1:0] off;
  logic [PROD_W-1:0]  prod_next;
  logic [RPROD_W-1:0] rprod;
  logic [PROD_W-1:0]  qs, rem;
  logic [COORD_W-1:0] q;
  logic [LUMA_W-1:0]  r8, g8, b8;
  logic [2*LUMA_W-1:0] lsum;
  logic [COORD_W-1:0] ax, ay;
  logic [ADDR_W-1:0]  addr_next;

  assign accept = req.valid && req.ready;

  // Classification of the incoming item
  assign in_frame  = ({1'b0, req.coord_x} < LW_C) && ({1'b0, req.coord_y} < LH_C);
  assign in_square = ({1'b0, req.coord_x} >= SQ_X_LO) && ({1'b0, req.coord_x} < SQ_X_HI) &&
                     ({1'b0, req.coord_y} >= SQ_Y_LO) && ({1'b0, req.coord_y} < SQ_Y_HI);

  // Shared scale unit: offset*LOGICAL, then floor divide by the square side
  assign off       = axis ? (cy - COORD_W'(SQUARE_OFF_Y)) : (cx - COORD_W'(SQUARE_OFF_X));
  assign prod_next = PROD_W'(off) * (axis ? PROD_W'(LOGICAL_HEIGHT) : PROD_W'(LOGICAL_WIDTH));
  assign rprod     = RPROD_W'(prod) * RPROD_W'(RECIP);
  assign qs        = PROD_W'(qest) * PROD_W'(SQUARE_SIDE);
  assign rem       = prod - qs;
  assign q         = (rem >= PROD_W'(SQUARE_SIDE)) ? (qest + COORD_W'(1)) : qest;

  // Luma from 8-bit expanded channels
  assign r8   = {color[COLOR_W-1 -: R_BITS], (LUMA_W-R_BITS)'(0)};
  assign g8   = {color[B_BITS +: G_BITS], (LUMA_W-G_BITS)'(0)};
  assign b8   = {color[B_BITS-1:0], (LUMA_W-B_BITS)'(0)};
  assign lsum = (2*LUMA_W)'(LUMA_KR) * (2*LUMA_W)'(r8) +
                (2*LUMA_W)'(LUMA_KG) * (2*LUMA_W)'(g8) +
                (2*LUMA_W)'(LUMA_KB) * (2*LUMA_W)'(b8);

  // Store address of the target pixel
  assign ax        = (kind == REQ_WRITE) ? cx : sx;
  assign ay        = (kind == REQ_WRITE) ? cy : sy;
  assign addr_next = ADDR_W'(ay) * ADDR_W'(LOGICAL_WIDTH) + ADDR_W'(ax);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      F_IDLE: begin
        if (accept) begin
          if (req.req_type == REQ_READ && in_square) state_next = F_SCALE;
          else if (req.req_type == REQ_WRITE && in_frame) state_next = F_ADDR;
          else state_next = F_PUSH;
        end
      end
      F_SCALE: state_next = F_RECIP;
      F_RECIP: state_next = F_FIX;
      F_FIX:   state_next = axis ? F_ADDR : F_SCALE;
      F_ADDR:  state_next = F_PUSH;
      F_PUSH:  if (!full) state_next = F_IDLE;
      default: state_next = F_IDLE;
    endcase
  end

  // Handshake outputs
  always_comb begin
    req.ready = (state == F_IDLE) && !clearing;
    push      = (state == F_PUSH) && !full;
  end

  assign push_cmd = cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= F_IDLE;
      luma_threshold <= LUMA_THRESHOLD_RESET;
    end else begin
      state <= state_next;
      if (cfg_we) luma_threshold <= cfg_wdata;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    case (state)
      F_IDLE: begin
        if (accept) begin
          kind      <= req.req_type;
          cx        <= req.coord_x;
          cy        <= req.coord_y;
          color     <= req.rgb_color;
          axis      <= 1'b0;
          cmd.op    <= CMD_REPLY;
          cmd.addr  <= '0;
          cmd.white <= 1'b1;
        end
      end
      F_SCALE: prod <= prod_next;
      F_RECIP: qest <= COORD_W'(rprod >> PROD_W);
      F_FIX: begin
        if (axis) sy <= q;
        else sx <= q;
        axis <= 1'b1;
      end
      F_ADDR: begin
        cmd.addr  <= addr_next;
        cmd.op    <= (kind == REQ_WRITE) ? CMD_WRITE : CMD_READ;
        cmd.white <= !(lsum[2*LUMA_W-1:LUMA_W] > luma_threshold);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== hw/rtl/rmfs_queue.sv =====
// Short command queue decoupling the front end from the store back end.
// Depends on rmfs_pkg (cmd_t, depth) and the assertion macro header.
`default_nettype none
`include "rgb565_to_mono_frame_scaler_core_assert.svh"

module rmfs_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rmfs_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output rmfs_pkg::cmd_t pop_cmd,
  output logic           empty
);
  import rmfs_pkg::*;

  cmd_t                 slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_PTR_W:0]   count;

  assign full    = (count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = slots[rd_ptr];

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + QUEUE_PTR_W'(1);
      if (pop)  rd_ptr <= rd_ptr + QUEUE_PTR_W'(1);
      if (push && !pop) count <= count + (QUEUE_PTR_W+1)'(1);
      else if (pop && !push) count <= count - (QUEUE_PTR_W+1)'(1);
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  `RMFS_ASSERT_SAME(a_no_push_when_full, clk, rst, full, !push)
  `RMFS_ASSERT_SAME(a_no_pop_when_empty, clk, rst, empty, !pop)

endmodule

`default_nettype wire

// ===== hw/rtl/rmfs_back.sv =====
// Back end: holds the 1-bit-per-pixel store, runs the clearing pass after reset,
// executes queued commands and drives the result channel. Depends on rmfs_pkg,
// rmfs_rsp_if and the assertion macro header.
`default_nettype none
`include "rgb565_to_mono_frame_scaler_core_assert.svh"

module rmfs_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           empty,
  input  rmfs_pkg::cmd_t pop_cmd,
  output logic           pop,
  output logic           clearing,
  rmfs_rsp_if.source     rsp
);
  import rmfs_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_BITS - 1);

  logic              mem [STORE_BITS];
  logic              clr_busy;
  logic [ADDR_W-1:0] clr_addr;
  logic              rd_bit;
  logic              s1_valid;
  cmd_op_t           s1_op;
  logic              s1_white;
  logic              rsp_valid, rsp_white, rsp_hit;

  logic              s1_adv;
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr;
  logic              mem_wdata;
  logic              res_white, res_hit;

  assign clearing = clr_busy;

  // Issue control
  assign s1_adv    = s1_valid && (!rsp_valid || rsp.ready);
  assign pop       = !clr_busy && !empty && (!s1_valid || s1_adv);
  assign mem_we    = clr_busy || (pop && pop_cmd.op == CMD_WRITE);
  assign mem_re    = pop && pop_cmd.op == CMD_READ;
  assign mem_waddr = clr_busy ? clr_addr : pop_cmd.addr;
  assign mem_wdata = clr_busy ? 1'b1 : pop_cmd.white;

  // Frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
  end

  always_ff @(posedge clk) begin
    if (mem_re) rd_bit <= mem[pop_cmd.addr];
  end

  // Clearing pass to all white after reset
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_busy <= 1'b1;
      clr_addr <= '0;
    end else if (clr_busy) begin
      clr_addr <= clr_addr + ADDR_W'(1);
      if (clr_addr == LAST_ADDR) clr_busy <= 1'b0;
    end
  end

  // Result of the command in stage 1
  always_comb begin
    case (s1_op)
      CMD_WRITE: begin
        res_white = s1_white;
        res_hit   = 1'b1;
      end
      CMD_READ: begin
        res_white = rd_bit;
        res_hit   = 1'b1;
      end
      CMD_REPLY: begin
        res_white = 1'b1;
        res_hit   = 1'b0;
      end
      default: begin
        res_white = 1'b1;
        res_hit   = 1'b0;
      end
    endcase
  end

  // Stage 1 and output register valids
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (pop) s1_valid <= 1'b1;
      else if (s1_adv) s1_valid <= 1'b0;
      if (s1_adv) rsp_valid <= 1'b1;
      else if (rsp.ready) rsp_valid <= 1'b0;
    end
  end

  // Stage 1 and output payload
  always_ff @(posedge clk) begin
    if (pop) begin
      s1_op    <= pop_cmd.op;
      s1_white <= pop_cmd.white;
    end
    if (s1_adv) begin
      rsp_white <= res_white;
      rsp_hit   <= res_hit;
    end
  end

  assign rsp.valid       = rsp_valid;
  assign rsp.pixel_white = rsp_white;
  assign rsp.in_range    = rsp_hit;

  `RMFS_ASSERT_SAME(a_no_issue_while_clearing, clk, rst, clr_busy, !pop)
  `RMFS_ASSERT_NEXT(a_clear_ends_at_last, clk, rst, clr_busy && clr_addr == LAST_ADDR, !clr_busy)
  `RMFS_ASSERT_NEXT(a_stage1_reaches_output, clk, rst, s1_adv, rsp_valid)

endmodule

`default_nettype wire
